/* hdl/kdtc_pkg.sv */
// Package for the keypad controlled dual tick counters.
// Holds widths, reset values, register indexes and the column pattern table.
// No dependencies.
package kdtc_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int CFG_WIDTH   = 16;
    localparam int TICK_WIDTH  = 16;
    localparam int KEY_WIDTH   = 4;
    localparam int ROW_WIDTH   = 3;
    localparam int COL_WIDTH   = 6;
    localparam int DIV_STEPS   = TICK_WIDTH;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [CFG_WIDTH-1:0] FRAME_LENGTH_RST   = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] PERIOD_ONE_RST     = 16'd500;
    localparam logic [CFG_WIDTH-1:0] PERIOD_TWO_RST     = 16'd333;
    localparam logic [CFG_WIDTH-1:0] DISPLAY_PERIOD_RST = 16'd100;

    localparam logic [KEY_WIDTH-1:0] KEY_NONE   = 4'd0;
    localparam logic [KEY_WIDTH-1:0] KEY_PAUSE1 = 4'd1;
    localparam logic [KEY_WIDTH-1:0] KEY_PAUSE2 = 4'd2;
    localparam logic [KEY_WIDTH-1:0] KEY_CLEAR  = 4'd3;
    localparam logic [KEY_WIDTH-1:0] KEY_TOG1   = 4'd4;
    localparam logic [KEY_WIDTH-1:0] KEY_TOG2   = 4'd5;
    localparam logic [KEY_WIDTH-1:0] KEY_ROW1   = 4'd1;
    localparam logic [KEY_WIDTH-1:0] KEY_ROW2   = 4'd4;
    localparam logic [KEY_WIDTH-1:0] KEY_ROW3   = 4'd7;

    localparam logic [1:0] LAST_COLUMN = 2'd2;

    typedef enum logic [1:0] {
        CFG_FRAME_LENGTH   = 2'd0,
        CFG_PERIOD_ONE     = 2'd1,
        CFG_PERIOD_TWO     = 2'd2,
        CFG_DISPLAY_PERIOD = 2'd3
    } t_cfg_index;

    function automatic logic [COL_WIDTH-1:0] col_pattern(input logic [1:0] col);
        logic [COL_WIDTH-1:0] pat;
        case (col)
            2'd0:    pat = 6'h3B;
            2'd1:    pat = 6'h3D;
            default: pat = 6'h3E;
        endcase
        return pat;
    endfunction

endpackage

/* hdl/keypad_controlled_dual_tick_counters_top.sv */
// Top level of the keypad controlled dual tick counters.
// Keypad scan, run flags, frame tick, two counters, strobe and remainder unit.
// Depends on kdtc_pkg.
//
// One tick request is taken per clock and its result appears in the output
// register on the next cycle; a waiting result does not block the next
// request unless the output is stalled. The frame position is tracked as a
// running remainder per period, so a write to period_one, period_two or
// display_period starts a shift-subtract pass (one bit per cycle)
// that rebuilds that remainder; both ready outputs are low during the pass.
module keypad_controlled_dual_tick_counters_top
    import kdtc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ROW_WIDTH-1:0]  i_row_levels,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COL_WIDTH-1:0]  o_column_drive,
    output logic [KEY_WIDTH-1:0]  o_key_code,
    output logic [31:0]           o_count_one,
    output logic [31:0]           o_count_two,
    output logic                  o_enabled_one,
    output logic                  o_enabled_two,
    output logic                  o_display_strobe,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_WIDTH-1:0]  i_cfg_data
);

    logic [CFG_WIDTH-1:0]   r_frame_length, r_period_one, r_period_two, r_display_period;
    logic [1:0]             r_scan_column, n_scan_column;
    logic [KEY_WIDTH-1:0]   r_held_key, n_held_key;
    logic                   r_press_seen, n_press_seen;
    logic                   r_armed_four, n_armed_four, r_armed_five, n_armed_five;
    logic                   r_run_one, n_run_one, r_run_two, n_run_two;
    logic [TICK_WIDTH-1:0]  r_frame_tick, n_frame_tick;
    logic [COUNT_WIDTH-1:0] r_value_one, n_value_one, r_value_two, n_value_two;
    logic [TICK_WIDTH-1:0]  r_res_one, n_res_one, r_res_two, n_res_two;
    logic [TICK_WIDTH-1:0]  r_res_disp, n_res_disp;

    logic                   r_busy;
    logic [DIV_CNT_W-1:0]   r_div_cnt;
    t_cfg_index             r_div_sel;
    logic [TICK_WIDTH-1:0]  r_rem;
    logic [TICK_WIDTH:0]    div_shift;
    logic [TICK_WIDTH-1:0]  div_period, div_rem;

    logic                   r_out_valid;
    logic [COL_WIDTH-1:0]   r_column_drive;
    logic [KEY_WIDTH-1:0]   r_key_code;
    logic [COUNT_WIDTH-1:0] r_count_one, r_count_two;
    logic                   r_enabled_one, r_enabled_two, r_display_strobe;

    logic                   in_fire, cfg_fire;
    logic                   en1, en2, hit1, hit2, hitd, wrap;
    logic [TICK_WIDTH-1:0]  tick_adv;
    logic [COUNT_WIDTH-1:0] base_one, base_two;

    assign o_in_ready  = !r_busy && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = !r_busy;
    assign in_fire     = i_in_valid && o_in_ready;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    function automatic logic [TICK_WIDTH-1:0] res_step(input logic [TICK_WIDTH-1:0] res,
                                                       input logic [TICK_WIDTH-1:0] per);
        logic [TICK_WIDTH:0] inc;
        inc = {1'b0, res} + 1'b1;
        return (inc == {1'b0, per}) ? '0 : inc[TICK_WIDTH-1:0];
    endfunction

    always_comb begin
        logic [TICK_WIDTH-1:0] s1, s2, sd;
        n_held_key   = r_held_key;
        n_press_seen = r_press_seen;
        if (!i_row_levels[0]) begin
            n_held_key   = KEY_ROW1 + KEY_WIDTH'(r_scan_column);
            n_press_seen = 1'b1;
        end
        if (!i_row_levels[1]) begin
            n_held_key   = KEY_ROW2 + KEY_WIDTH'(r_scan_column);
            n_press_seen = 1'b1;
        end
        if (!i_row_levels[2]) begin
            n_held_key   = KEY_ROW3 + KEY_WIDTH'(r_scan_column);
            n_press_seen = 1'b1;
        end
        if (r_scan_column >= LAST_COLUMN) begin
            n_scan_column = 2'd0;
            if (!n_press_seen) begin
                n_held_key = KEY_NONE;
            end
            n_press_seen = 1'b0;
        end else begin
            n_scan_column = r_scan_column + 2'd1;
        end

        n_run_one    = r_run_one;
        n_armed_four = r_armed_four;
        if (r_armed_four && n_held_key == KEY_NONE) begin
            n_run_one    = !r_run_one;
            n_armed_four = 1'b0;
        end else if (n_held_key == KEY_TOG1) begin
            n_armed_four = 1'b1;
        end
        n_run_two    = r_run_two;
        n_armed_five = r_armed_five;
        if (r_armed_five && n_held_key == KEY_NONE) begin
            n_run_two    = !r_run_two;
            n_armed_five = 1'b0;
        end else if (n_held_key == KEY_TOG2) begin
            n_armed_five = 1'b1;
        end

        base_one = (n_held_key == KEY_CLEAR) ? '0 : r_value_one;
        base_two = (n_held_key == KEY_CLEAR) ? '0 : r_value_two;
        en1 = n_run_one && n_held_key != KEY_PAUSE1;
        en2 = n_run_two && n_held_key != KEY_PAUSE2;

        tick_adv = r_frame_tick + 1'b1;
        s1 = res_step(r_res_one, r_period_one);
        s2 = res_step(r_res_two, r_period_two);
        sd = res_step(r_res_disp, r_display_period);
        hit1 = r_period_one != '0 && s1 == '0;
        hit2 = r_period_two != '0 && s2 == '0;
        hitd = r_display_period != '0 && sd == '0;
        wrap = tick_adv >= r_frame_length;

        n_value_one  = (hit1 && en1) ? base_one + 1'b1 : base_one;
        n_value_two  = (hit2 && en2) ? base_two + 1'b1 : base_two;
        n_frame_tick = wrap ? '0 : tick_adv;
        n_res_one    = wrap ? '0 : s1;
        n_res_two    = wrap ? '0 : s2;
        n_res_disp   = wrap ? '0 : sd;
    end

    // remainder unit: frame tick mod written period, one bit per cycle
    always_comb begin
        unique case (r_div_sel)
            CFG_PERIOD_ONE:     div_period = r_period_one;
            CFG_PERIOD_TWO:     div_period = r_period_two;
            CFG_DISPLAY_PERIOD: div_period = r_display_period;
            CFG_FRAME_LENGTH:   div_period = r_frame_length;
        endcase
        div_shift = {r_rem, r_frame_tick[(DIV_CNT_W)'(DIV_STEPS - 1) - r_div_cnt]};
        div_rem   = (div_shift >= {1'b0, div_period})
                  ? TICK_WIDTH'(div_shift - {1'b0, div_period})
                  : div_shift[TICK_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length   <= FRAME_LENGTH_RST;
            r_period_one     <= PERIOD_ONE_RST;
            r_period_two     <= PERIOD_TWO_RST;
            r_display_period <= DISPLAY_PERIOD_RST;
            r_scan_column    <= '0;
            r_held_key       <= KEY_NONE;
            r_press_seen     <= 1'b0;
            r_armed_four     <= 1'b0;
            r_armed_five     <= 1'b0;
            r_run_one        <= 1'b1;
            r_run_two        <= 1'b1;
            r_frame_tick     <= '0;
            r_value_one      <= '0;
            r_value_two      <= '0;
            r_res_one        <= '0;
            r_res_two        <= '0;
            r_res_disp       <= '0;
            r_busy           <= 1'b0;
            r_div_cnt        <= '0;
            r_div_sel        <= CFG_FRAME_LENGTH;
            r_rem            <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (cfg_fire) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_FRAME_LENGTH:   r_frame_length   <= i_cfg_data;
                    CFG_PERIOD_ONE:     r_period_one     <= i_cfg_data;
                    CFG_PERIOD_TWO:     r_period_two     <= i_cfg_data;
                    CFG_DISPLAY_PERIOD: r_display_period <= i_cfg_data;
                endcase
                r_busy    <= t_cfg_index'(i_cfg_index) != CFG_FRAME_LENGTH;
                r_div_sel <= t_cfg_index'(i_cfg_index);
                r_div_cnt <= '0;
                r_rem     <= '0;
            end else if (r_busy) begin
                r_rem     <= div_rem;
                r_div_cnt <= r_div_cnt + 1'b1;
                if (r_div_cnt == (DIV_CNT_W)'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    unique case (r_div_sel)
                        CFG_PERIOD_ONE:     r_res_one  <= div_rem;
                        CFG_PERIOD_TWO:     r_res_two  <= div_rem;
                        CFG_DISPLAY_PERIOD: r_res_disp <= div_rem;
                        CFG_FRAME_LENGTH:   ;
                    endcase
                end
            end

            if (in_fire) begin
                r_scan_column <= n_scan_column;
                r_held_key    <= n_held_key;
                r_press_seen  <= n_press_seen;
                r_armed_four  <= n_armed_four;
                r_armed_five  <= n_armed_five;
                r_run_one     <= n_run_one;
                r_run_two     <= n_run_two;
                r_frame_tick  <= n_frame_tick;
                r_value_one   <= n_value_one;
                r_value_two   <= n_value_two;
                r_res_one     <= n_res_one;
                r_res_two     <= n_res_two;
                r_res_disp    <= n_res_disp;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_column_drive   <= col_pattern(n_scan_column);
            r_key_code       <= n_held_key;
            r_count_one      <= n_value_one;
            r_count_two      <= n_value_two;
            r_enabled_one    <= en1;
            r_enabled_two    <= en2;
            r_display_strobe <= hitd;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_column_drive   = r_column_drive;
    assign o_key_code       = r_key_code;
    assign o_count_one      = 32'(r_count_one);
    assign o_count_two      = 32'(r_count_two);
    assign o_enabled_one    = r_enabled_one;
    assign o_enabled_two    = r_enabled_two;
    assign o_display_strobe = r_display_strobe;

    a_res_one_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && r_period_one != '0) |-> (r_res_one < r_period_one))
        else $error("counter one remainder out of range");

    a_res_disp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && r_display_period != '0) |-> (r_res_disp < r_display_period))
        else $error("display remainder out of range");

    a_scan_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_column != 2'd3)
        else $error("scan column left the keypad");

    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted request produced no result");

endmodule
